FILE: rtl/core/pnm_stream_to_rgb_decoder_unit_assert.svh
// Assertion macros for the PNM decoder.
`ifndef PNM_STREAM_TO_RGB_DECODER_UNIT_ASSERT_SVH
`define PNM_STREAM_TO_RGB_DECODER_UNIT_ASSERT_SVH
// Concurrent implication checked on every clock.
`define PNM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication.
`define PNM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: rtl/core/pnm_pkg.sv
// ---------------------------------------------------------------------------
// pnm_pkg: shared types and constants of the PNM decoder
// Beat structs, result kinds, controller/datapath command and status.
// ---------------------------------------------------------------------------
`default_nettype none
package pnm_pkg;
  localparam int unsigned MaxWidthDef  = 4096;
  localparam int unsigned MaxHeightDef = 4096;

  localparam logic [1:0] KindPixel  = 2'd0;
  localparam logic [1:0] KindHeader = 2'd1;
  localparam logic [1:0] KindError  = 2'd2;

  localparam logic [7:0] ChP    = 8'h50;
  localparam logic [7:0] ChHash = 8'h23;
  localparam logic [16:0] TokenCap = 17'h1FFFF;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       restart;
  } pnm_in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [11:0] column;
    logic [11:0] row;
    logic [12:0] image_width;
    logic [12:0] image_height;
    logic [2:0]  format;
    logic        image_done;
    logic        last;
  } pnm_out_t;

  // controller -> datapath
  typedef struct packed {
    logic start_div;   // begin scaling of token value
  } pnm_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic       div_done;
    logic [7:0] scaled;
  } pnm_sts_t;

  function automatic logic is_ws(input logic [7:0] b);
    return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39);
  endfunction
endpackage
`default_nettype wire

FILE: rtl/core/pnm_scaler.sv
// ---------------------------------------------------------------------------
// pnm_scaler: ASCII sample scaling unit
// Computes min(255, floor(255*v/maxval)) by restoring division, one bit a cycle.
// ---------------------------------------------------------------------------
`default_nettype none
module pnm_scaler
  import pnm_pkg::*;
(
  input  var logic        clk_i,
  input  var logic        rst_ni,
  input  var pnm_cmd_t    cmd_i,
  input  var logic [16:0] value_i,
  input  var logic [15:0] maxval_i,
  output var pnm_sts_t    sts_o
);
  // 255*v fits 25 bits; quotient needs 25 bits but is clamped to 8.
  localparam int unsigned NW = 25;
  logic [NW-1:0] num_q, num_d;
  logic [NW-1:0] quo_q, quo_d;
  logic [16:0]   rem_q, rem_d;
  logic [4:0]    cnt_q, cnt_d;
  logic          busy_q, busy_d, done_q, done_d;
  logic [15:0]   den;
  logic [17:0]   trial;
  logic [16:0]   shifted;

  assign den     = (maxval_i == 16'd0) ? 16'd1 : maxval_i;
  assign shifted = {rem_q[15:0], num_q[NW-1]};
  assign trial   = {1'b0, shifted} - {2'b00, den};

  always_comb begin
    num_d = num_q; quo_d = quo_q; rem_d = rem_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0;
    if (cmd_i.start_div) begin
      num_d  = NW'({value_i, 8'h00} - {8'h00, value_i});
      quo_d  = '0; rem_d = '0; cnt_d = 5'(NW); busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[NW-2:0], 1'b0};
      if (!trial[17]) begin
        rem_d = trial[16:0];
        quo_d = {quo_q[NW-2:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[NW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d; quo_q <= quo_d; rem_q <= rem_d;
  end

  assign sts_o.div_done = done_q;
  assign sts_o.scaled   = (quo_q > NW'(255)) ? 8'hFF : quo_q[7:0];
endmodule
`default_nettype wire

FILE: rtl/core/pnm_ctrl.sv
// ---------------------------------------------------------------------------
// pnm_ctrl: parser controller
// Header parse, token scan, pixel sequencing and result beat output.
// ---------------------------------------------------------------------------
`default_nettype none
module pnm_ctrl
  import pnm_pkg::*;
#(
  parameter int unsigned MaxWidth  = MaxWidthDef,
  parameter int unsigned MaxHeight = MaxHeightDef
) (
  input  var logic        clk_i,
  input  var logic        rst_ni,
  input  var logic        in_valid_i,
  output var logic        in_ready_o,
  input  var pnm_in_t     in_data_i,
  output var logic        out_valid_o,
  input  var logic        out_ready_i,
  output var pnm_out_t    out_data_o,
  output var pnm_cmd_t    cmd_o,
  output var logic [16:0] value_o,
  output var logic [15:0] maxval_o,
  input  var pnm_sts_t    sts_i
);
  typedef enum logic [3:0] {
    PhMagicP, PhMagicDigit, PhMagicSep, PhWidth, PhHeight, PhMaxval,
    PhRaw, PhAscii, PhDone, PhError
  } phase_e;

  typedef enum logic [1:0] {StIdle, StEmit, StWait} st_e;

  phase_e      phase_q;
  st_e         st_q;
  logic [2:0]  fmt_q;
  logic [12:0] width_q, height_q;
  logic [15:0] maxval_q;
  logic [16:0] tok_q;
  logic [16:0] sval_q;
  logic        tok_act_q, in_cmt_q;
  logic [11:0] col_q, row_q;
  logic [1:0]  comp_q;
  logic [7:0]  hred_q, hgrn_q;
  // pending pixel burst (raw bitmap) or single result
  logic [7:0]  bits_q;
  logic [3:0]  npix_q;
  logic        pend_pix_q;
  logic [7:0]  pr_q, pg_q, pb_q;
  logic        ovalid_q;
  pnm_out_t    obeat_q;
  logic        bitmap_q;

  assign in_ready_o  = (st_q == StIdle) && !ovalid_q;
  assign out_valid_o = ovalid_q;
  assign out_data_o  = obeat_q;
  // finished sample token, held for the scaler
  assign value_o     = sval_q;
  assign maxval_o    = maxval_q;

  // next position
  logic [11:0] col_nx, row_nx;
  logic        done_nx;
  always_comb begin
    col_nx = col_q + 12'd1;
    row_nx = row_q;
    if ({1'b0, col_nx} >= width_q || col_q == 12'hFFF) begin
      col_nx = '0; row_nx = row_q + 12'd1;
    end
    done_nx = ({1'b0, row_nx} >= height_q) || (row_nx == 12'd0 && row_q == 12'hFFF);
  end

  logic [20:0] tok_mul;
  logic [7:0]  b;
  logic        ws;
  assign tok_mul = {tok_q, 3'b000} + {2'b00, tok_q, 1'b0} + 21'(b - 8'h30);
  assign b  = in_data_i.byte_in;
  assign ws = is_ws(b);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhMagicP; st_q <= StIdle; fmt_q <= '0; width_q <= '0;
      height_q <= '0; maxval_q <= '0; tok_q <= '0; tok_act_q <= 1'b0;
      in_cmt_q <= 1'b0; col_q <= '0; row_q <= '0; comp_q <= '0;
      hred_q <= '0; hgrn_q <= '0; ovalid_q <= 1'b0; obeat_q <= '0;
      bits_q <= '0; npix_q <= '0; pend_pix_q <= 1'b0; sval_q <= '0;
      pr_q <= '0; pg_q <= '0; pb_q <= '0; cmd_o <= '0; bitmap_q <= 1'b0;
    end else begin
      cmd_o.start_div <= 1'b0;
      if (ovalid_q && out_ready_i) ovalid_q <= 1'b0;
      unique case (st_q)
        StIdle: begin
          if (in_valid_i && in_ready_o) begin
            phase_e ph;
            logic [16:0] v;
            logic        tok_end;
            logic        bad;
            ph = in_data_i.restart ? PhMagicP : phase_q;
            tok_end = 1'b0; bad = 1'b0; v = tok_q;
            if (in_data_i.restart) begin
              fmt_q <= '0; width_q <= '0; height_q <= '0; maxval_q <= '0;
              tok_q <= '0; tok_act_q <= 1'b0; in_cmt_q <= 1'b0;
              col_q <= '0; row_q <= '0; comp_q <= '0;
            end
            // token scan for header and ASCII phases
            if (ph == PhWidth || ph == PhHeight || ph == PhMaxval || ph == PhAscii) begin
              if (in_cmt_q && !in_data_i.restart) begin
                if (b == 8'h0A || b == 8'h0D) in_cmt_q <= 1'b0;
              end else if (ws) begin
                if (tok_act_q && !in_data_i.restart) begin
                  tok_end = 1'b1; tok_q <= '0; tok_act_q <= 1'b0;
                end
              end else if (b == ChHash && !(tok_act_q && !in_data_i.restart)) begin
                in_cmt_q <= 1'b1;
              end else if (is_digit(b)) begin
                tok_q <= (tok_mul > 21'(TokenCap)) ? TokenCap : tok_mul[16:0];
                tok_act_q <= 1'b1;
              end else begin
                bad = 1'b1;
              end
            end
            unique case (ph)
              PhMagicP: if (b == ChP) phase_q <= PhMagicDigit; else bad = 1'b1;
              PhMagicDigit: begin
                if (b >= 8'h31 && b <= 8'h36) begin
                  fmt_q <= 3'(b - 8'h30); phase_q <= PhMagicSep;
                end else bad = 1'b1;
              end
              PhMagicSep: if (ws) phase_q <= PhWidth; else bad = 1'b1;
              PhWidth: if (tok_end && !bad) begin
                if (v == 0 || v > 17'(MaxWidth)) bad = 1'b1;
                else begin width_q <= v[12:0]; phase_q <= PhHeight; end
              end
              PhHeight: if (tok_end && !bad) begin
                if (v == 0 || v > 17'(MaxHeight)) bad = 1'b1;
                else begin
                  height_q <= v[12:0];
                  if (fmt_q == 3'd1 || fmt_q == 3'd4) begin
                    ovalid_q <= 1'b1;
                    obeat_q <= '{kind: KindHeader, image_width: width_q,
                                 image_height: v[12:0], format: fmt_q, last: 1'b1,
                                 default: '0};
                    col_q <= '0; row_q <= '0; comp_q <= '0;
                    phase_q <= (fmt_q >= 3'd4) ? PhRaw : PhAscii;
                  end else phase_q <= PhMaxval;
                end
              end
              PhMaxval: if (tok_end && !bad) begin
                if (v == 0 || v > 17'd65535) bad = 1'b1;
                else begin
                  maxval_q <= v[15:0];
                  ovalid_q <= 1'b1;
                  obeat_q <= '{kind: KindHeader, image_width: width_q,
                               image_height: height_q, format: fmt_q, last: 1'b1,
                               default: '0};
                  col_q <= '0; row_q <= '0; comp_q <= '0;
                  phase_q <= (fmt_q >= 3'd4) ? PhRaw : PhAscii;
                end
              end
              PhRaw: begin
                if (fmt_q == 3'd4) begin
                  logic [12:0] rem;
                  rem = width_q - {1'b0, col_q};
                  bits_q <= b;
                  npix_q <= (rem > 13'd8) ? 4'd8 : rem[3:0];
                  bitmap_q <= 1'b1; st_q <= StEmit;
                end else if (fmt_q == 3'd5) begin
                  pr_q <= b; pg_q <= b; pb_q <= b; npix_q <= 4'd1;
                  bitmap_q <= 1'b0; st_q <= StEmit;
                end else begin
                  unique case (comp_q)
                    2'd0: begin hred_q <= b; comp_q <= 2'd1; end
                    2'd1: begin hgrn_q <= b; comp_q <= 2'd2; end
                    default: begin
                      comp_q <= 2'd0; pr_q <= hred_q; pg_q <= hgrn_q; pb_q <= b;
                      npix_q <= 4'd1; bitmap_q <= 1'b0; st_q <= StEmit;
                    end
                  endcase
                end
              end
              PhAscii: if (tok_end && !bad) begin
                if (fmt_q == 3'd1) begin
                  pr_q <= (v != 0) ? 8'h00 : 8'hFF;
                  pg_q <= (v != 0) ? 8'h00 : 8'hFF;
                  pb_q <= (v != 0) ? 8'h00 : 8'hFF;
                  npix_q <= 4'd1; bitmap_q <= 1'b0; st_q <= StEmit;
                end else begin
                  sval_q <= v;
                  cmd_o.start_div <= 1'b1; st_q <= StWait;
                end
              end
              default: ;
            endcase
            if (bad) begin
              ovalid_q <= 1'b1;
              obeat_q <= '{kind: KindError, last: 1'b1, default: '0};
              phase_q <= PhError; st_q <= StIdle;
            end
          end
        end
        StWait: begin
          if (sts_i.div_done) begin
            if (fmt_q == 3'd2) begin
              pr_q <= sts_i.scaled; pg_q <= sts_i.scaled; pb_q <= sts_i.scaled;
              npix_q <= 4'd1; bitmap_q <= 1'b0; st_q <= StEmit;
            end else begin
              unique case (comp_q)
                2'd0: begin hred_q <= sts_i.scaled; comp_q <= 2'd1; st_q <= StIdle; end
                2'd1: begin hgrn_q <= sts_i.scaled; comp_q <= 2'd2; st_q <= StIdle; end
                default: begin
                  comp_q <= 2'd0; pr_q <= hred_q; pg_q <= hgrn_q; pb_q <= sts_i.scaled;
                  npix_q <= 4'd1; bitmap_q <= 1'b0; st_q <= StEmit;
                end
              endcase
            end
          end
        end
        StEmit: begin
          if (!ovalid_q || out_ready_i) begin
            logic [7:0] c;
            logic       lst;
            c   = bits_q[7] ? 8'h00 : 8'hFF;
            lst = (npix_q == 4'd1) || done_nx;
            ovalid_q <= 1'b1;
            obeat_q <= '{kind: KindPixel,
                         red: bitmap_q ? c : pr_q, green: bitmap_q ? c : pg_q,
                         blue: bitmap_q ? c : pb_q, column: col_q, row: row_q,
                         image_width: 13'd0, image_height: 13'd0, format: fmt_q,
                         image_done: done_nx, last: lst};
            col_q <= col_nx; row_q <= row_nx;
            bits_q <= {bits_q[6:0], 1'b0};
            npix_q <= npix_q - 4'd1;
            if (done_nx) phase_q <= PhDone;
            if (lst) st_q <= StIdle;
          end
        end
        default: st_q <= StIdle;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/pnm_stream_to_rgb_decoder_unit.sv
// PNM decoder: takes a P1..P6 file one byte a beat and returns header, pixel
// and error beats. Assert restart with the first byte of a file. The input
// stays closed while a result beat waits in the single output register, and
// while the controller emits pixels or waits on the scaler, so no new byte is
// taken before the last one is through. A raw gray byte or final raw color
// byte is accepted, emitted and then handed off; a raw bitmap byte yields one
// pixel beat for each pixel it holds (up to 8). A whitespace byte that ends an
// ASCII gray or color sample runs the bit-serial scaling divider.
// ---------------------------------------------------------------------------
// pnm_stream_to_rgb_decoder_unit: top level
// Controller plus scaling datapath.
// ---------------------------------------------------------------------------
`default_nettype none
`include "pnm_stream_to_rgb_decoder_unit_assert.svh"
module pnm_stream_to_rgb_decoder_unit
  import pnm_pkg::*;
#(
  parameter int unsigned MaxWidth  = MaxWidthDef,
  parameter int unsigned MaxHeight = MaxHeightDef
) (
  input  var logic     clk_i,
  input  var logic     rst_ni,
  input  var logic     in_valid_i,
  output var logic     in_ready_o,
  input  var pnm_in_t  in_data_i,
  output var logic     out_valid_o,
  input  var logic     out_ready_i,
  output var pnm_out_t out_data_o
);
  pnm_cmd_t    cmd;
  pnm_sts_t    sts;
  logic [16:0] value;
  logic [15:0] maxval;

  pnm_ctrl #(.MaxWidth(MaxWidth), .MaxHeight(MaxHeight)) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o,
    .cmd_o(cmd), .value_o(value), .maxval_o(maxval), .sts_i(sts)
  );

  pnm_scaler u_scaler (
    .clk_i, .rst_ni, .cmd_i(cmd), .value_i(value), .maxval_i(maxval), .sts_o(sts)
  );

  // a held result beat keeps its payload
  `PNM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
                   out_valid_o && $stable(out_data_o))
  // input is never taken while a beat is pending
  `PNM_ASSERT_IMP(a_no_accept_pending, clk_i, rst_ni, out_valid_o, !in_ready_o)
  // scaling never completes while input is open
  `PNM_ASSERT_IMP(a_div_closed, clk_i, rst_ni, sts.div_done, !in_ready_o)
endmodule
`default_nettype wire
